[hdl/tdf_pkg.sv]
// Shared widths, types and sequencer states for the trial-division factorizer.
`timescale 1ns / 1ps

package tdf_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	localparam value_t FIRST_DIVISOR = value_t'(2);
	localparam value_t UNIT_VALUE    = value_t'(1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   done;
		value_t quo;
		value_t rem;
	} div_rsp_t;

endpackage

[hdl/tdf_in_if.sv]
// Input channel: one value to factorize per word.
`timescale 1ns / 1ps

interface tdf_in_if;
	logic                  valid;
	logic                  ready;
	tdf_pkg::value_t       number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

[hdl/tdf_out_if.sv]
// Output channel: one prime factor per word, with end and no-factor marks.
`timescale 1ns / 1ps

interface tdf_out_if;
	logic                  valid;
	logic                  ready;
	tdf_pkg::value_t       factor;
	logic                  last;
	logic                  no_factors;

	modport source (output valid, output factor, output last, output no_factors, input ready);
	modport sink   (input valid, input factor, input last, input no_factors, output ready);
endinterface

[hdl/tdf_divider.sv]
// Restoring divider: one quotient bit per cycle, quotient and remainder held after done.
`timescale 1ns / 1ps

module tdf_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  tdf_pkg::div_req_t req,
	output tdf_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [tdf_pkg::DIV_CNT_W-1:0]  cnt_q;
	tdf_pkg::value_t                rem_q;
	tdf_pkg::value_t                quo_q;
	tdf_pkg::value_t                div_q;

	logic [tdf_pkg::VALUE_WIDTH:0]  shifted;
	logic [tdf_pkg::VALUE_WIDTH:0]  diff;
	logic                           fits;

	assign shifted = {rem_q, quo_q[tdf_pkg::VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = ~diff[tdf_pkg::VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tdf_pkg::DIV_CNT_W'(tdf_pkg::VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - tdf_pkg::DIV_CNT_W'(1);
				if (cnt_q == tdf_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			// take the difference as the partial remainder only when the divisor fits
			rem_q <= fits ? diff[tdf_pkg::VALUE_WIDTH-1:0] : shifted[tdf_pkg::VALUE_WIDTH-1:0];
			quo_q <= {quo_q[tdf_pkg::VALUE_WIDTH-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

[hdl/tdf_ctrl.sv]
// Sequencer: walks the trial divisors, divides out hits and drives the output register.
`timescale 1ns / 1ps

module tdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	tdf_in_if.sink            items,
	tdf_out_if.source         factors,
	output tdf_pkg::div_req_t div_req,
	input  tdf_pkg::div_rsp_t div_rsp
);

	tdf_pkg::state_t state_q, state_d;

	tdf_pkg::value_t rest_q;
	tdf_pkg::value_t d_q;
	logic            inner_q;
	logic            fin_q;

	tdf_pkg::value_t fac_q;
	logic            last_q;
	logic            nof_q;

	logic            out_valid_q;
	tdf_pkg::value_t out_factor_q;
	logic            out_last_q;
	logic            out_nof_q;

	logic small_in;
	logic quit;
	logic hit;
	logic slot_free;
	logic out_load;
	logic accept;

	assign small_in  = items.number < tdf_pkg::FIRST_DIVISOR;
	// divisor squared above the rest ends the search; skip the check while dividing out
	assign quit      = !inner_q && (div_rsp.quo < d_q);
	assign hit       = div_rsp.rem == '0;
	assign slot_free = !out_valid_q || factors.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tdf_pkg::S_IDLE: begin
				if (items.valid) begin
					state_d = small_in ? tdf_pkg::S_EMIT : tdf_pkg::S_START;
				end
			end
			tdf_pkg::S_START: begin
				state_d = tdf_pkg::S_WAIT;
			end
			tdf_pkg::S_WAIT: begin
				if (div_rsp.done) begin
					if (quit) begin
						state_d = (rest_q > tdf_pkg::UNIT_VALUE) ? tdf_pkg::S_EMIT
						                                         : tdf_pkg::S_IDLE;
					end else if (hit) begin
						state_d = tdf_pkg::S_EMIT;
					end else begin
						state_d = tdf_pkg::S_START;
					end
				end
			end
			tdf_pkg::S_EMIT: begin
				if (slot_free) begin
					state_d = fin_q ? tdf_pkg::S_IDLE : tdf_pkg::S_START;
				end
			end
			default: state_d = tdf_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		items.ready      = state_q == tdf_pkg::S_IDLE;
		accept           = items.valid && (state_q == tdf_pkg::S_IDLE);
		div_req.start    = state_q == tdf_pkg::S_START;
		div_req.dividend = rest_q;
		div_req.divisor  = d_q;
		out_load         = (state_q == tdf_pkg::S_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdf_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			inner_q     <= 1'b0;
			fin_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (factors.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				inner_q <= 1'b0;
				fin_q   <= small_in;
			end else if ((state_q == tdf_pkg::S_WAIT) && div_rsp.done) begin
				if (quit) begin
					fin_q <= 1'b1;
				end else if (hit) begin
					inner_q <= 1'b1;
					fin_q   <= div_rsp.quo == tdf_pkg::UNIT_VALUE;
				end else begin
					inner_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rest_q <= items.number;
			d_q    <= tdf_pkg::FIRST_DIVISOR;
			fac_q  <= '0;
			last_q <= 1'b1;
			nof_q  <= 1'b1;
		end else if ((state_q == tdf_pkg::S_WAIT) && div_rsp.done) begin
			if (quit) begin
				// leftover above one is the final prime
				fac_q  <= rest_q;
				last_q <= 1'b1;
				nof_q  <= 1'b0;
			end else if (hit) begin
				fac_q  <= d_q;
				last_q <= div_rsp.quo == tdf_pkg::UNIT_VALUE;
				nof_q  <= 1'b0;
				rest_q <= div_rsp.quo;
			end else begin
				d_q <= d_q + tdf_pkg::UNIT_VALUE;
			end
		end
		if (out_load) begin
			out_factor_q <= fac_q;
			out_last_q   <= last_q;
			out_nof_q    <= nof_q;
		end
	end

	assign factors.valid      = out_valid_q;
	assign factors.factor     = out_factor_q;
	assign factors.last       = out_last_q;
	assign factors.no_factors = out_nof_q;

	a_done_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == tdf_pkg::S_WAIT)
		else $error("divider result arrived outside wait state");

	a_divisor_min: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tdf_pkg::S_START |-> d_q >= tdf_pkg::FIRST_DIVISOR)
		else $error("trial divisor below two");

	a_factor_min: assert property (@(posedge clk) disable iff (!arst_n)
		factors.valid && !factors.no_factors |-> factors.factor >= tdf_pkg::FIRST_DIVISOR)
		else $error("emitted factor below two");

	a_no_factor_word: assert property (@(posedge clk) disable iff (!arst_n)
		factors.valid && factors.no_factors |-> factors.last && (factors.factor == '0))
		else $error("no-factor word malformed");

endmodule

[hdl/trial_division_factorizer.sv]
// Top level of the trial-division prime factorizer.
`timescale 1ns / 1ps

// Takes one unsigned 31-bit value per input word and returns its prime factors in
// ascending order, with repeats, one factor per output word; the final word of each
// value carries last. Inputs 0 and 1 give a single word with factor zero, last and
// no_factors set. One value is worked on at a time and the input is not ready until
// its last factor has been handed to the output register. Each trial divisor costs one
// pass of the restoring divider, plus an emit step per factor that waits while the
// output register is full; the search runs while the divisor squared is at most the
// remaining value, so a prime near two to the thirty-first takes about 46341 passes.
// The output register lets a new value be taken while the previous final factor still
// waits.
module trial_division_factorizer (
	input  logic      clk,
	input  logic      arst_n,
	tdf_in_if.sink    items,
	tdf_out_if.source factors
);

	tdf_pkg::div_req_t div_req;
	tdf_pkg::div_rsp_t div_rsp;

	tdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.factors (factors),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	tdf_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

[tb/trial_division_factorizer_tb.sv]
// Self-checking testbench for the trial-division prime factorizer.
`timescale 1ns / 1ps

module trial_division_factorizer_tb;

	localparam int QUIET_LIMIT    = 5_000_000;
	localparam int HOLDOFF_CYCLES = 6000;
	localparam int RANDOM_ITEMS   = 82;
	localparam int SETTLE_CYCLES  = 200;

	localparam int N_DIRECTED = 18;
	localparam tdf_pkg::value_t DIRECTED_NUMBERS [N_DIRECTED] = '{
		0, 1, 2, 3, 4, 6, 49, 97, 9409, 9973, 10403, 19946, 65536, 994009,
		1073741824, 1610612736, 2147483646, 2147483647
	};

	localparam int N_SMALL_PRIMES = 25;
	localparam int SMALL_PRIMES [N_SMALL_PRIMES] = '{
		2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
		53, 59, 61, 67, 71, 73, 79, 83, 89, 97
	};

	typedef struct packed {
		tdf_pkg::value_t factor;
		logic            last;
		logic            no_factors;
	} factor_word_t;

	typedef struct {
		tdf_pkg::value_t number;
		bit              drain_first;
	} number_item_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_HALF,
		READY_MOSTLY,
		READY_EVERY_FOURTH
	} ready_style_t;

	logic clk;
	logic arst_n;

	tdf_in_if  number_ch ();
	tdf_out_if factor_ch ();

	trial_division_factorizer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (number_ch),
		.factors (factor_ch)
	);

	number_item_t numbers_to_send [$];
	factor_word_t pending_factors [$];

	logic         drained;
	int           values_taken;
	int           words_checked;
	int           mismatches;
	int           burst_left;
	int           gap_left;
	int           hold_cycles;
	int           holdoffs;
	int           words_taken;
	int           style_cycles;
	ready_style_t ready_style;
	int           quiet_cycles = 0;

	// Expected factor words of one value, appended in output order.
	function automatic void push_prime_factors(input tdf_pkg::value_t number);
		longint unsigned rest;
		longint unsigned d;
		factor_word_t    w;
		rest = 64'(number);
		if (rest <= 64'(tdf_pkg::UNIT_VALUE)) begin
			w = '{factor: '0, last: 1'b1, no_factors: 1'b1};
			pending_factors.push_back(w);
			return;
		end
		d = 64'(tdf_pkg::FIRST_DIVISOR);
		while (d <= rest / d) begin
			while (rest % d == 0) begin
				w = '{factor: tdf_pkg::value_t'(d), last: 1'b0, no_factors: 1'b0};
				pending_factors.push_back(w);
				rest = rest / d;
			end
			d++;
		end
		if (rest > 64'(tdf_pkg::UNIT_VALUE)) begin
			w = '{factor: tdf_pkg::value_t'(rest), last: 1'b0, no_factors: 1'b0};
			pending_factors.push_back(w);
		end
		pending_factors[pending_factors.size() - 1].last = 1'b1;
	endfunction

	// Mostly smooth numbers: small primes times an optional cofactor below 10000,
	// kept under a random ceiling so every width up to the full one shows up.
	function automatic tdf_pkg::value_t draw_number();
		longint unsigned v;
		longint unsigned ceiling;
		longint unsigned p;
		int              misses;
		if ($urandom_range(0, 19) == 0)
			return tdf_pkg::value_t'($urandom_range(0, 1));
		if ($urandom_range(0, 6) == 0)
			return tdf_pkg::value_t'($urandom_range(0, 65535));
		ceiling = (64'd1 << $urandom_range(2, tdf_pkg::VALUE_WIDTH)) - 1;
		v = ($urandom_range(0, 2) == 0) ? longint'($urandom_range(2, 9999)) : 1;
		if (v > ceiling)
			v = 1;
		misses = 0;
		while (misses < 6) begin
			p = SMALL_PRIMES[$urandom_range(0, $urandom_range(0, N_SMALL_PRIMES - 1))];
			if (v * p <= ceiling)
				v = v * p;
			else
				misses++;
		end
		return tdf_pkg::value_t'(v);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : stimulus
		number_item_t item;
		arst_n = 1'b0;
		foreach (DIRECTED_NUMBERS[i]) begin
			item.number      = DIRECTED_NUMBERS[i];
			item.drain_first = 1'b0;
			numbers_to_send.push_back(item);
		end
		// Drain before the random part and once again halfway through it.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			item.number      = draw_number();
			item.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
			numbers_to_send.push_back(item);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (numbers_to_send.size() != 0 || number_ch.valid || !drained)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_factors.size() != 0) begin
			$error("%0d expected factor words never arrived", pending_factors.size());
		end
		$display("%0d values factored, %0d factor words checked", values_taken, words_checked);
		$display("%0d long output hold-offs, two drain pauses on the input side", holdoffs);
		if (mismatches == 0 && pending_factors.size() == 0) begin
			$display("trial_division_factorizer_tb: done, clean");
		end else begin
			$display("trial_division_factorizer_tb: done, errors");
		end
		$finish;
	end

	// Sender: bursts of words with random gaps; hold a flagged word until drained.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_ch.valid  <= 1'b0;
			number_ch.number <= '0;
			burst_left       <= 1;
			gap_left         <= 0;
		end else if (!number_ch.valid || number_ch.ready) begin
			if (gap_left > 0) begin
				gap_left        <= gap_left - 1;
				number_ch.valid <= 1'b0;
			end else if (numbers_to_send.size() == 0 ||
			             (numbers_to_send[0].drain_first &&
			              (!drained || (number_ch.valid && number_ch.ready)))) begin
				number_ch.valid <= 1'b0;
			end else begin
				number_ch.valid  <= 1'b1;
				number_ch.number <= numbers_to_send[0].number;
				void'(numbers_to_send.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					if ($urandom_range(0, 3) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left <= $urandom_range(30, 60);
					else
						gap_left <= $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: changing stall styles, plus two long hold-offs to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_ch.ready <= 1'b0;
			hold_cycles  = 0;
			holdoffs     = 0;
			words_taken  = 0;
			style_cycles = 0;
			ready_style  = READY_ALWAYS;
		end else begin
			if (factor_ch.valid && factor_ch.ready)
				words_taken++;
			if (hold_cycles > 0) begin
				hold_cycles--;
				factor_ch.ready <= 1'b0;
			end else if (holdoffs < 2 && words_taken >= (holdoffs == 0 ? 25 : 75)) begin
				hold_cycles = HOLDOFF_CYCLES;
				holdoffs++;
				factor_ch.ready <= 1'b0;
			end else begin
				if (style_cycles == 0) begin
					ready_style  = ready_style_t'($urandom_range(0, 3));
					style_cycles = $urandom_range(20, 120);
				end else begin
					style_cycles--;
				end
				case (ready_style)
					READY_ALWAYS:       factor_ch.ready <= 1'b1;
					READY_HALF:         factor_ch.ready <= 1'($urandom_range(0, 1));
					READY_MOSTLY:       factor_ch.ready <= ($urandom_range(0, 3) != 0);
					READY_EVERY_FOURTH: factor_ch.ready <= (style_cycles % 4 == 0);
					default:            factor_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Check each factor word against the oldest expectation, then predict new input.
	always @(posedge clk or negedge arst_n) begin : monitor
		factor_word_t want;
		if (!arst_n) begin
			drained       <= 1'b1;
			values_taken  = 0;
			words_checked = 0;
			mismatches    = 0;
		end else begin
			if (factor_ch.valid && factor_ch.ready) begin
				if (pending_factors.size() == 0) begin
					$error("unexpected factor word: factor %0d last %0b no_factors %0b",
					       factor_ch.factor, factor_ch.last, factor_ch.no_factors);
					mismatches++;
				end else begin
					want = pending_factors.pop_front();
					words_checked++;
					if (factor_ch.factor !== want.factor) begin
						$error("factor: expected %0d, got %0d", want.factor, factor_ch.factor);
						mismatches++;
					end
					if (factor_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, factor_ch.last);
						mismatches++;
					end
					if (factor_ch.no_factors !== want.no_factors) begin
						$error("no_factors: expected %0b, got %0b",
						       want.no_factors, factor_ch.no_factors);
						mismatches++;
					end
				end
			end
			if (number_ch.valid && number_ch.ready) begin
				push_prime_factors(number_ch.number);
				values_taken++;
			end
			drained <= (pending_factors.size() == 0);
		end
	end

	// Watchdog: a long stretch with no word moving on either side ends the run.
	always @(posedge clk) begin
		if ((number_ch.valid && number_ch.ready) || (factor_ch.valid && factor_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no word moved for %0d cycles", QUIET_LIMIT);
			$display("trial_division_factorizer_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

[sim.f]
hdl/tdf_pkg.sv
hdl/tdf_in_if.sv
hdl/tdf_out_if.sv
hdl/tdf_divider.sv
hdl/tdf_ctrl.sv
hdl/trial_division_factorizer.sv
tb/trial_division_factorizer_tb.sv
